// ===== rtl/core/pnlr_pkg.sv =====
// shared types and constants of the packed nibble line rasterizer
`default_nettype none
package pnlr_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 512;
    localparam int PITCH_MAX   = 4 * (((MAX_WIDTH * 4 + 7) / 8 + 3) / 4);
    localparam int STORE_DEPTH = PITCH_MAX * MAX_HEIGHT;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam int XW  = 10;
    localparam int YW  = 9;
    localparam int CW  = 4;
    localparam int LWW = 6;
    localparam int IMG_WW = 11;
    localparam int IMG_HW = 10;
    localparam int IN_W  = 56;
    localparam int OUT_W = 8;

    // command codes on the input word
    localparam logic [1:0] FUNC_LINE = 2'd0;
    localparam logic [1:0] FUNC_FILL = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    typedef enum logic [1:0] {
        KIND_DRAW,
        KIND_FILL,
        KIND_READ,
        KIND_NONE
    } kind_t;

    // decoded command handed from front to back
    typedef struct packed {
        kind_t            kind;
        logic             err;
        logic [XW-1:0]    x1;
        logic [YW-1:0]    y1;
        logic [XW-1:0]    x2;
        logic [YW-1:0]    y2;
        logic [CW-1:0]    color;
        logic [LWW-1:0]   lw;
        logic             up;
        logic             down;
        logic             xmajor;
        logic [XW:0]      dx;
        logic [YW:0]      dy;
    } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/pnlr_front.sv =====
// front end: decodes and range checks commands, orders line endpoints
`default_nettype none
module pnlr_front (
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [pnlr_pkg::IN_W-1:0] s_tdata,
    input  wire logic [pnlr_pkg::IMG_WW-1:0] w_eff,
    input  wire logic [pnlr_pkg::IMG_HW-1:0] h_eff,
    input  wire logic                      q_full,
    output logic                           q_push,
    output pnlr_pkg::cmd_t                 q_cmd
);
    logic [1:0]                   func;
    logic [pnlr_pkg::XW-1:0]      sx, ex;
    logic [pnlr_pkg::YW-1:0]      sy, ey;
    logic                         swap, bad_s, bad_e;
    logic [pnlr_pkg::YW-1:0]      ady;
    pnlr_pkg::cmd_t               c;

    assign func = s_tdata[1:0];
    assign sx   = s_tdata[11:2];
    assign sy   = s_tdata[20:12];
    assign ex   = s_tdata[30:21];
    assign ey   = s_tdata[39:31];

    // range checks against the effective frame size
    assign bad_s = ({1'b0, sx} >= w_eff) || ({1'b0, sy} >= h_eff);
    assign bad_e = ({1'b0, ex} >= w_eff) || ({1'b0, ey} >= h_eff);
    assign swap  = ex < sx;

    // classify and order endpoints so x rises
    always_comb begin
        c        = '0;
        c.kind   = pnlr_pkg::KIND_NONE;
        c.color  = s_tdata[43:40];
        c.lw     = s_tdata[49:44];
        c.x1     = swap ? ex : sx;
        c.y1     = swap ? ey : sy;
        c.x2     = swap ? sx : ex;
        c.y2     = swap ? sy : ey;
        c.up     = c.y2 > c.y1;
        c.down   = c.y2 < c.y1;
        ady      = c.up ? (c.y2 - c.y1) : (c.y1 - c.y2);
        c.dx     = {1'b0, c.x2} - {1'b0, c.x1} + 11'd1;
        c.dy     = {1'b0, ady} + 10'd1;
        c.xmajor = c.dx > {1'b0, c.dy};
        unique case (func)
            pnlr_pkg::FUNC_LINE: begin
                c.err  = bad_s || bad_e;
                c.kind = c.err ? pnlr_pkg::KIND_NONE : pnlr_pkg::KIND_DRAW;
            end
            pnlr_pkg::FUNC_FILL: begin
                c.kind = pnlr_pkg::KIND_FILL;
            end
            pnlr_pkg::FUNC_READ: begin
                c.x1   = sx;
                c.y1   = sy;
                c.err  = bad_s;
                c.kind = c.err ? pnlr_pkg::KIND_NONE : pnlr_pkg::KIND_READ;
            end
            default: begin
                c.kind = pnlr_pkg::KIND_NONE;
            end
        endcase
    end

    assign s_tready = aresetn && !q_full;
    assign q_push   = s_tvalid && s_tready;
    assign q_cmd    = c;

endmodule
`default_nettype wire

// ===== rtl/core/pnlr_queue.sv =====
// two entry command queue between front and back
`default_nettype none
module pnlr_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire pnlr_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output logic                full,
    output logic                not_empty,
    output pnlr_pkg::cmd_t      head
);
    pnlr_pkg::cmd_t ent_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign head      = ent_reg[rd_ptr_reg];

    // entries
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/pnlr_back.sv =====
// back end: line stepping, fill sweep, pixel read and the frame store
`default_nettype none
module pnlr_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_valid,
    input  wire pnlr_pkg::cmd_t              q_head,
    output logic                             q_pop,
    input  wire logic [pnlr_pkg::IMG_WW-1:0] w_eff,
    input  wire logic [pnlr_pkg::IMG_HW-1:0] h_eff,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [pnlr_pkg::OUT_W-1:0]       m_tdata
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_LSTART, ST_LDOT, ST_LSTEP, ST_FILL, ST_READ, ST_RESP
    } state_t;

    localparam int AW = pnlr_pkg::STORE_AW;

    state_t state_reg;
    pnlr_pkg::cmd_t cmd_reg;
    logic [pnlr_pkg::XW:0]     cx_reg;
    logic signed [11:0]        cy_reg;
    logic [20:0]               accx_reg, accy_reg;
    logic [pnlr_pkg::XW-1:0]   px_reg;
    logic [pnlr_pkg::YW-1:0]   py_reg;
    logic [16:0]               wx_reg, wy_reg;
    logic [pnlr_pkg::LWW-1:0]  k_reg;
    logic [pnlr_pkg::YW-1:0]   fy_reg;
    logic [pnlr_pkg::YW-1:0]   fbx_reg;
    logic                      status_reg;
    logic                      out_valid_reg;
    logic [pnlr_pkg::OUT_W-1:0] out_data_reg;

    logic                      wr_hi_reg, wr_lo_reg;
    logic [pnlr_pkg::YW-1:0]   wr_y_reg, wr_bx_reg;
    logic [pnlr_pkg::CW-1:0]   wr_c_reg;
    logic [pnlr_pkg::CW-1:0]   rd_hi_reg, rd_lo_reg;

    logic [pnlr_pkg::CW-1:0]   mem_hi [pnlr_pkg::STORE_DEPTH];
    logic [pnlr_pkg::CW-1:0]   mem_lo [pnlr_pkg::STORE_DEPTH];

    logic [9:0]  used, pitch;
    logic [AW:0] wr_addr_full, rd_addr_full;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [pnlr_pkg::YW-1:0] ymax;
    logic [10:0] w_m1;
    logic [9:0]  h_m1;
    logic        take;
    logic signed [11:0] cy_next;
    logic [20:0] accx_next;
    logic signed [12:0] dcy;
    logic [12:0] adcy;
    logic        again;

    // row pitch: used bytes rounded up to four
    assign used  = w_eff[10:1] + {9'd0, w_eff[0]};
    assign pitch = {used[9:2] + {7'd0, |used[1:0]}, 2'b00};
    assign w_m1  = w_eff - 11'd1;
    assign h_m1  = h_eff - 10'd1;
    assign ymax  = cmd_reg.up ? cmd_reg.y2 : cmd_reg.y1;

    assign wr_addr_full = (AW+1)'(wr_y_reg * pitch) + (AW+1)'(wr_bx_reg);
    assign wr_addr      = wr_addr_full[AW-1:0];
    assign rd_addr_full = (AW+1)'(cmd_reg.y1 * pitch) + (AW+1)'(cmd_reg.x1[9:1]);
    assign rd_addr      = rd_addr_full[AW-1:0];

    // frame store, one nibble array per column parity
    always_ff @(posedge aclk) begin
        if (wr_hi_reg) mem_hi[wr_addr] <= wr_c_reg;
        if (wr_lo_reg) mem_lo[wr_addr] <= wr_c_reg;
        rd_hi_reg <= mem_hi[rd_addr];
        rd_lo_reg <= mem_lo[rd_addr];
    end

    // accumulator step at the end of one inner pass
    always_comb begin
        take      = accy_reg >= accx_reg;
        cy_next   = cy_reg;
        accx_next = accx_reg;
        if (take) begin
            if (cmd_reg.up)        cy_next = cy_reg + 12'sd1;
            else if (cmd_reg.down) cy_next = cy_reg - 12'sd1;
            accx_next = accx_reg + 21'(cmd_reg.dx);
        end
        dcy   = 13'(cy_next) - $signed({4'd0, cmd_reg.y1});
        adcy  = dcy[12] ? 13'(-dcy) : 13'(dcy);
        again = (accy_reg >= accx_next) && (adcy <= 13'(cmd_reg.dy - 10'd1));
    end

    assign q_pop    = q_valid && (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            wr_hi_reg     <= 1'b0;
            wr_lo_reg     <= 1'b0;
        end else begin
            wr_hi_reg <= 1'b0;
            wr_lo_reg <= 1'b0;
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        cmd_reg    <= q_head;
                        status_reg <= q_head.err;
                        cx_reg     <= {1'b0, q_head.x1};
                        cy_reg     <= 12'(q_head.y1);
                        accx_reg   <= 21'(q_head.dx[10:1]);
                        accy_reg   <= 21'(q_head.dy);
                        fy_reg     <= '0;
                        fbx_reg    <= '0;
                        unique case (q_head.kind)
                            pnlr_pkg::KIND_DRAW: state_reg <= ST_LSTART;
                            pnlr_pkg::KIND_FILL: state_reg <=
                                (h_eff == '0 || used == '0) ? ST_RESP : ST_FILL;
                            pnlr_pkg::KIND_READ: state_reg <= ST_READ;
                            default:             state_reg <= ST_RESP;
                        endcase
                    end
                end
                ST_LSTART: begin
                    px_reg <= cx_reg[pnlr_pkg::XW-1:0];
                    if (cy_reg > $signed({3'd0, ymax})) py_reg <= ymax;
                    else if (cy_reg < 12'sd0)           py_reg <= '0;
                    else                                py_reg <= cy_reg[pnlr_pkg::YW-1:0];
                    wx_reg    <= '0;
                    wy_reg    <= '0;
                    k_reg     <= '0;
                    state_reg <= ST_LDOT;
                end
                ST_LDOT: begin
                    if (k_reg == cmd_reg.lw) begin
                        state_reg <= ST_LSTEP;
                    end else begin
                        wr_hi_reg <= !px_reg[0];
                        wr_lo_reg <= px_reg[0];
                        wr_y_reg  <= py_reg;
                        wr_bx_reg <= px_reg[9:1];
                        wr_c_reg  <= cmd_reg.color;
                        k_reg     <= k_reg + 6'd1;
                        if (wx_reg < wy_reg) begin
                            wx_reg <= wx_reg + 17'(cmd_reg.dx);
                            if (cmd_reg.xmajor) begin
                                if (px_reg > '0) px_reg <= px_reg - 10'd1;
                            end else begin
                                if ({1'b0, px_reg} < w_m1) px_reg <= px_reg + 10'd1;
                            end
                        end else begin
                            wy_reg <= wy_reg + 17'(cmd_reg.dy);
                            if (cmd_reg.up == cmd_reg.xmajor) begin
                                if ({1'b0, py_reg} < h_m1) py_reg <= py_reg + 9'd1;
                            end else begin
                                if (py_reg > '0) py_reg <= py_reg - 9'd1;
                            end
                        end
                    end
                end
                ST_LSTEP: begin
                    cy_reg   <= cy_next;
                    accx_reg <= accx_next;
                    if (again) begin
                        state_reg <= ST_LSTART;
                    end else begin
                        accy_reg <= accy_reg + 21'(cmd_reg.dy);
                        cx_reg   <= cx_reg + 11'd1;
                        state_reg <= (cx_reg == {1'b0, cmd_reg.x2}) ? ST_RESP : ST_LSTART;
                    end
                end
                ST_FILL: begin
                    wr_hi_reg <= 1'b1;
                    wr_lo_reg <= 1'b1;
                    wr_y_reg  <= fy_reg;
                    wr_bx_reg <= fbx_reg;
                    wr_c_reg  <= cmd_reg.color;
                    if ({1'b0, fbx_reg} == used - 10'd1) begin
                        fbx_reg <= '0;
                        fy_reg  <= fy_reg + 9'd1;
                        if ({1'b0, fy_reg} == h_m1) state_reg <= ST_RESP;
                    end else begin
                        fbx_reg <= fbx_reg + 9'd1;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_RESP;
                end
                ST_RESP: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {3'd0, status_reg,
                            (cmd_reg.kind == pnlr_pkg::KIND_READ)
                                ? (cmd_reg.x1[0] ? rd_lo_reg : rd_hi_reg) : 4'd0};
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // dots stay inside the frame's rows
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_hi_reg || wr_lo_reg) |-> ({1'b0, wr_y_reg} < h_eff))
        else $error("store write beyond last row");
    // side steps never pass the requested count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LDOT) |-> (k_reg <= cmd_reg.lw))
        else $error("side step count overrun");
    // a waiting result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("result lost while stalled");
    // commands only leave the queue when the engine is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (state_reg != ST_IDLE))
        else $error("command taken without dispatch");

endmodule
`default_nettype wire

// ===== rtl/core/packed_nibble_line_rasterizer_core.sv =====
// top level: configuration registers, front end, queue and back end
// Usage: commands enter on s_t* (one word each), one result word leaves on
// m_t* per command, in order. cfg_wr_en/cfg_addr/cfg_wdata write image_width
// (index 0) and image_height (index 1) while no command is in flight.
// A line is drawn by the stepping loop, each inner pass plotting
// line_width dots, between a dispatch step and a result step; fill writes
// every used byte of the frame (up to 262144); a read looks up one pixel;
// an error or unused command only returns its status word. A single
// back-end sequencer works on one command at a time.
// The front end decodes and range checks into a two word queue, so up to
// two further commands are taken while the back end works.
// Reset (aresetn low, synchronous) empties the queue, idles the sequencer,
// drops any pending result and sets width 500, height 300; the frame store
// is not cleared and holds unknown values until written.
// A stalled receiver holds the result in the output register; the back end
// waits at its next result; the front end stops at a full queue.
`default_nettype none
module packed_nibble_line_rasterizer_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // func, start_x, start_y, end_x, end_y, color, line_width, zero pad
    input  wire logic [pnlr_pkg::IN_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // pixel_value, status, zero pad
    output logic [pnlr_pkg::OUT_W-1:0]         m_tdata,
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_addr,
    input  wire logic [pnlr_pkg::IMG_WW-1:0]   cfg_wdata
);
    logic [pnlr_pkg::IMG_WW-1:0] width_reg, w_eff;
    logic [pnlr_pkg::IMG_HW-1:0] height_reg, h_eff;
    logic           q_full, q_push, q_pop, q_valid;
    pnlr_pkg::cmd_t q_cmd, q_head;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 11'd500;
            height_reg <= 10'd300;
        end else if (cfg_wr_en) begin
            if (cfg_addr == 1'b0) width_reg  <= cfg_wdata;
            else                  height_reg <= cfg_wdata[pnlr_pkg::IMG_HW-1:0];
        end
    end

    // clamp to the store's size
    assign w_eff = (width_reg > 11'(pnlr_pkg::MAX_WIDTH))
                 ? 11'(pnlr_pkg::MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg > 10'(pnlr_pkg::MAX_HEIGHT))
                 ? 10'(pnlr_pkg::MAX_HEIGHT) : height_reg;

    pnlr_front u_front (
        .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .w_eff(w_eff), .h_eff(h_eff),
        .q_full(q_full), .q_push(q_push), .q_cmd(q_cmd)
    );

    pnlr_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_cmd(q_cmd), .pop(q_pop),
        .full(q_full), .not_empty(q_valid), .head(q_head)
    );

    pnlr_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
        .w_eff(w_eff), .h_eff(h_eff),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// testbench for the packed nibble line rasterizer core: directed and random commands
`timescale 1ns / 1ps
module tb_top;

    localparam int STORE_BYTES = 262144;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    // func, start_x, start_y, end_x, end_y, color, line_width, zero pad
    logic [pnlr_pkg::IN_W-1:0] s_tdata = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    // pixel_value, status, zero pad
    logic [pnlr_pkg::OUT_W-1:0] m_tdata;
    logic            cfg_wr_en = 1'b0;
    logic            cfg_addr = 1'b0;
    logic [pnlr_pkg::IMG_WW-1:0] cfg_wdata = '0;

    packed_nibble_line_rasterizer_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    typedef struct {
        logic [3:0] pixel;
        logic       status;
    } pix_result_t;

    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam logic       REG_WIDTH  = 1'b0;
    localparam logic       REG_HEIGHT = 1'b1;

    // predictor state: frame bytes and registers
    logic [7:0]  frame_bytes [STORE_BYTES];
    int unsigned img_w = 500;
    int unsigned img_h = 300;

    pix_result_t pending_pixels [$];
    int          mismatches = 0;
    bit          failed = 1'b0;
    int          burst_left = 0;

    always #5 aclk = ~aclk;

    function automatic int row_pitch(int w);
        return 4 * (((w * 4 + 7) / 8 + 3) / 4);
    endfunction

    function automatic void plot_dot(int x, int y, int pitch, logic [3:0] c);
        int addr;
        addr = y * pitch + x / 2;
        if (addr >= STORE_BYTES) return;
        if (x % 2 == 0) frame_bytes[addr] = {c, frame_bytes[addr][3:0]};
        else frame_bytes[addr] = {frame_bytes[addr][7:4], c};
    endfunction

    // accumulator stepping with perpendicular thickening
    function automatic void trace_line(int x1, int y1, int x2, int y2, logic [3:0] c,
                                       int lw, int w, int h);
        int pitch, ymax, t, dx, dy, accx, accy, cx, cy, x, y, wx, wy;
        pitch = row_pitch(w);
        ymax = (y2 > y1) ? y2 : y1;
        if (x2 < x1) begin
            t = x1; x1 = x2; x2 = t;
            t = y1; y1 = y2; y2 = t;
        end
        dx = x2 - x1 + 1;
        dy = ((y2 > y1) ? y2 - y1 : y1 - y2) + 1;
        accx = dx / 2;
        accy = dy;
        cy = y1;
        for (cx = x1; cx <= x2; cx++) begin
            do begin
                x = cx;
                y = (cy > ymax) ? ymax : cy;
                if (y < 0) y = 0;
                wx = 0;
                wy = 0;
                for (int k = 0; k < lw; k++) begin
                    plot_dot(x, y, pitch, c);
                    if (dx > dy) begin
                        if (wx < wy) begin
                            wx += dx;
                            if (x > 0) x--;
                        end else begin
                            wy += dy;
                            if (y2 > y1) begin if (y < h - 1) y++; end
                            else begin if (y > 0) y--; end
                        end
                    end else begin
                        if (wx < wy) begin
                            wx += dx;
                            if (x < w - 1) x++;
                        end else begin
                            wy += dy;
                            if (y2 > y1) begin if (y > 0) y--; end
                            else begin if (y < h - 1) y++; end
                        end
                    end
                end
                if (accy >= accx) begin
                    if (y2 > y1) cy++;
                    else if (y2 < y1) cy--;
                    accx += dx;
                end
            end while (accy >= accx &&
                       ((cy > y1) ? cy - y1 : y1 - cy) <= ((y2 > y1) ? y2 - y1 : y1 - y2));
            accy += dy;
        end
    endfunction

    // predict the result word of one command and update the frame copy
    function automatic pix_result_t rasterize_cmd(logic [pnlr_pkg::IN_W-1:0] word);
        pix_result_t r;
        int fn, sx, sy, ex, ey, lw, w, h, pitch, addr;
        logic [3:0] c;
        fn = word[1:0];   sx = word[11:2];  sy = word[20:12];
        ex = word[30:21]; ey = word[39:31]; c = word[43:40]; lw = word[49:44];
        w = (img_w > pnlr_pkg::MAX_WIDTH) ? pnlr_pkg::MAX_WIDTH : img_w;
        h = (img_h > pnlr_pkg::MAX_HEIGHT) ? pnlr_pkg::MAX_HEIGHT : img_h;
        pitch = row_pitch(w);
        r.pixel = 4'd0;
        r.status = 1'b0;
        if (fn == pnlr_pkg::FUNC_LINE) begin
            if (sx >= w || ex >= w || sy >= h || ey >= h) r.status = 1'b1;
            else trace_line(sx, sy, ex, ey, c, lw, w, h);
        end else if (fn == pnlr_pkg::FUNC_FILL) begin
            for (int yy = 0; yy < h; yy++)
                for (int bx = 0; bx < (w + 1) / 2; bx++) begin
                    addr = yy * pitch + bx;
                    if (addr < STORE_BYTES) frame_bytes[addr] = {c, c};
                end
        end else if (fn == pnlr_pkg::FUNC_READ) begin
            if (sx >= w || sy >= h) r.status = 1'b1;
            else begin
                addr = sy * pitch + sx / 2;
                r.pixel = (sx % 2 == 0) ? frame_bytes[addr][7:4] : frame_bytes[addr][3:0];
            end
        end
        return r;
    endfunction

    function automatic logic [pnlr_pkg::IN_W-1:0] cmd_word(logic [1:0] fn, int sx, int sy,
                                                           int ex, int ey, int c, int lw);
        logic [pnlr_pkg::IN_W-1:0] wd;
        wd = '0;
        wd[1:0] = fn;                wd[11:2] = sx[9:0];  wd[20:12] = sy[8:0];
        wd[30:21] = ex[9:0];         wd[39:31] = ey[8:0];
        wd[43:40] = c[3:0];          wd[49:44] = lw[5:0];
        return wd;
    endfunction

    // send one word, with bursts and random gaps
    task automatic send_cmd(logic [pnlr_pkg::IN_W-1:0] word);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk) s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        pending_pixels.push_back(rasterize_cmd(word));
    endtask

    // stop sending and wait for all outstanding results
    task automatic drain();
        @(negedge aclk) s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, int val);
        drain();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[pnlr_pkg::IMG_WW-1:0];
        if (idx == REG_WIDTH) img_w = val & 32'h7FF;
        else img_h = val & 32'h3FF;
        @(negedge aclk) cfg_wr_en <= 1'b0;
    endtask

    task automatic set_size(int w, int h);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    // receiver stall pattern
    int rx_mode = 0;
    int rx_left = 0;
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left--;
        end
        m_tready <= (rx_mode == 0) ? 1'b1 :
                    (rx_mode == 1) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) == 0);
    end

    // result checker
    always @(posedge aclk) begin
        pix_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", m_tdata);
            end else begin
                want = pending_pixels.pop_front();
                if (m_tdata[3:0] !== want.pixel || m_tdata[4] !== want.status) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: pixel exp %0d got %0d, status exp %0d got %0d",
                                 want.pixel, m_tdata[3:0], want.status, m_tdata[4]);
                end
            end
        end
    end

    // whole frame filled once so no read ever hits an unwritten byte
    task automatic test_full_fill();
        set_size(pnlr_pkg::MAX_WIDTH, pnlr_pkg::MAX_HEIGHT);
        send_cmd(cmd_word(pnlr_pkg::FUNC_FILL, 0, 0, 0, 0, 5, 0));
        send_cmd(cmd_word(pnlr_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0));
        send_cmd(cmd_word(pnlr_pkg::FUNC_READ, 1023, 511, 0, 0, 0, 0));
        drain();
    endtask

    task automatic test_directed_lines();
        send_cmd(cmd_word(pnlr_pkg::FUNC_LINE, 0, 0, 1023, 511, 15, 1));
        send_cmd(cmd_word(pnlr_pkg::FUNC_LINE, 5, 0, 6, 511, 10, 63));
        // falling line, stepping is clamped at its lower end
        send_cmd(cmd_word(pnlr_pkg::FUNC_LINE, 0, 511, 20, 0, 3, 3));
        // thickening saturates at row 0
        send_cmd(cmd_word(pnlr_pkg::FUNC_LINE, 1000, 0, 1023, 0, 12, 63));
        send_cmd(cmd_word(pnlr_pkg::FUNC_LINE, 30, 10, 2, 40, 9, 4));
        send_cmd(cmd_word(pnlr_pkg::FUNC_LINE, 7, 7, 7, 7, 6, 0));
        send_cmd(cmd_word(pnlr_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0));
        send_cmd(cmd_word(pnlr_pkg::FUNC_READ, 1023, 511, 0, 0, 0, 0));
        send_cmd(cmd_word(pnlr_pkg::FUNC_READ, 1023, 0, 0, 0, 0, 0));
        send_cmd(cmd_word(pnlr_pkg::FUNC_READ, 6, 300, 0, 0, 0, 0));
        send_cmd(cmd_word(pnlr_pkg::FUNC_READ, 1, 510, 0, 0, 0, 0));
        send_cmd(cmd_word(FUNC_SPARE, 1023, 511, 1023, 511, 15, 63));
        drain();
    endtask

    task automatic test_edge_sizes();
        // odd width leaves row padding untouched by fill
        set_size(37, 13);
        send_cmd(cmd_word(pnlr_pkg::FUNC_FILL, 0, 0, 0, 0, 10, 0));
        send_cmd(cmd_word(pnlr_pkg::FUNC_LINE, 37, 0, 0, 0, 1, 1));
        send_cmd(cmd_word(pnlr_pkg::FUNC_LINE, 0, 0, 0, 13, 1, 1));
        send_cmd(cmd_word(pnlr_pkg::FUNC_READ, 36, 12, 0, 0, 0, 0));
        send_cmd(cmd_word(pnlr_pkg::FUNC_READ, 37, 0, 0, 0, 0, 0));
        send_cmd(cmd_word(pnlr_pkg::FUNC_READ, 0, 13, 0, 0, 0, 0));
        // zero width, then zero height
        set_size(0, 300);
        send_cmd(cmd_word(pnlr_pkg::FUNC_FILL, 0, 0, 0, 0, 3, 0));
        send_cmd(cmd_word(pnlr_pkg::FUNC_LINE, 0, 0, 0, 0, 3, 2));
        send_cmd(cmd_word(pnlr_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0));
        set_size(500, 0);
        send_cmd(cmd_word(pnlr_pkg::FUNC_FILL, 0, 0, 0, 0, 3, 0));
        send_cmd(cmd_word(pnlr_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0));
        set_size(1, 1);
        send_cmd(cmd_word(pnlr_pkg::FUNC_LINE, 0, 0, 0, 0, 4, 63));
        send_cmd(cmd_word(pnlr_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0));
        drain();
    endtask

    // one random phase under a given frame size
    task automatic random_phase(int w, int h, int count, bit big);
        int wu, hu, pick, sx, sy, ex, ey, lw;
        set_size(w, h);
        wu = (w > pnlr_pkg::MAX_WIDTH) ? pnlr_pkg::MAX_WIDTH : w;
        hu = (h > pnlr_pkg::MAX_HEIGHT) ? pnlr_pkg::MAX_HEIGHT : h;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (i == count / 2) begin
                // let everything settle mid phase
                drain();
            end
            if (pick < 10 || wu == 0 || hu == 0) begin
                send_cmd(cmd_word(2'($urandom_range(0, 2)) == pnlr_pkg::FUNC_FILL && big
                                      ? pnlr_pkg::FUNC_READ : 2'($urandom_range(0, 2)),
                                  $urandom_range(0, 1023), $urandom_range(0, 511),
                                  $urandom_range(0, 1023), $urandom_range(0, 511),
                                  $urandom_range(0, 15), $urandom_range(0, 63)));
            end else if (pick < 14) begin
                send_cmd(cmd_word(FUNC_SPARE, $urandom_range(0, 1023), $urandom_range(0, 511),
                                  $urandom_range(0, 1023), $urandom_range(0, 511),
                                  $urandom_range(0, 15), $urandom_range(0, 63)));
            end else if (pick < 22 && !big) begin
                send_cmd(cmd_word(pnlr_pkg::FUNC_FILL, 0, 0, 0, 0, $urandom_range(0, 15), 0));
            end else if (pick < 55) begin
                send_cmd(cmd_word(pnlr_pkg::FUNC_READ, $urandom_range(0, wu - 1),
                                  $urandom_range(0, hu - 1),
                                  $urandom_range(0, 1023), $urandom_range(0, 511),
                                  $urandom_range(0, 15), $urandom_range(0, 63)));
            end else begin
                sx = $urandom_range(0, wu - 1);
                sy = $urandom_range(0, hu - 1);
                if (big) begin
                    ex = sx + $urandom_range(0, 30) - 15;
                    ey = sy + $urandom_range(0, 30) - 15;
                    ex = (ex < 0) ? 0 : (ex >= wu) ? wu - 1 : ex;
                    ey = (ey < 0) ? 0 : (ey >= hu) ? hu - 1 : ey;
                end else begin
                    ex = $urandom_range(0, wu - 1);
                    ey = $urandom_range(0, hu - 1);
                end
                lw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6);
                send_cmd(cmd_word(pnlr_pkg::FUNC_LINE, sx, sy, ex, ey,
                                  $urandom_range(0, 15), lw));
            end
        end
        drain();
    endtask

    task automatic test_random();
        random_phase(64, 32, 110, 1'b0);
        random_phase(17, 9, 90, 1'b0);
        random_phase(1, 1, 40, 1'b0);
        random_phase(40, 64, 100, 1'b0);
        random_phase(8, 512, 80, 1'b0);
        // oversized registers act as the maximum frame
        random_phase(2047, 1023, 100, 1'b1);
        random_phase(0, 0, 30, 1'b0);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        test_full_fill();
        test_directed_lines();
        test_edge_sizes();
        test_random();
        drain();
        repeat (50) @(posedge aclk);
        if (!failed && pending_pixels.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/pnlr_pkg.sv
rtl/core/pnlr_front.sv
rtl/core/pnlr_queue.sv
rtl/core/pnlr_back.sv
rtl/core/packed_nibble_line_rasterizer_core.sv
sim/tb_top.sv
